// File: src/ptbd_pkg.sv
// ----------------------------------------------------------------------------
// ptbd_pkg
// Shared types, constants and helper functions of the planar tile block
// decompressor.
// ----------------------------------------------------------------------------
package ptbd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] HDR_RAW     = 8'h2A;
  localparam logic [7:0] HDR_BAD_MIN = 8'hC0;

  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned REPLAY_DEPTH = 9;

  // One compressed byte and its end-of-stream mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // Handshake between the input queue and the decoder.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_RAW,
    PH_MAP,
    PH_FLAGS,
    PH_ROWS
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAWPAD,
    ST_PLANES,
    ST_ROWS,
    ST_REPLAY,
    ST_ENDC,
    ST_FIN,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] short_map(input logic [1:0] sel);
    logic [7:0] m;
    case (sel)
      2'd0:    m = 8'h00;
      2'd1:    m = 8'h55;
      2'd2:    m = 8'hAA;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // 8x8 bit transpose: bit 8*m+i moves to bit 8*i+m.
  function automatic logic [63:0] transpose8x8(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      for (int m = 0; m < 8; m++) begin
        r[8*i+m] = v[8*m+i];
      end
    end
    return r;
  endfunction

endpackage

// File: src/ptbd_front.sv
// ----------------------------------------------------------------------------
// ptbd_front
// Input side: accepts compressed bytes and queues them for the decoder.
// ----------------------------------------------------------------------------
module ptbd_front import ptbd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // stream_end
  output queue_out_t q_out,
  input  logic       q_pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t           mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push;
  logic            pop;

  assign in_tready   = (count_r != CW'(DEPTH));
  assign push        = in_tvalid && in_tready;
  assign pop         = q_pop && (count_r != '0);
  assign q_out.valid = (count_r != '0);
  assign q_out.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_tdata, last: in_tlast};
    end
  end

endmodule

// File: src/ptbd_back.sv
// ----------------------------------------------------------------------------
// ptbd_back
// Decoder: runs the header, raw, plane and replay sequencing and drives the
// registered output stage.
// ----------------------------------------------------------------------------
module ptbd_back import ptbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  queue_out_t q_in,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tlast,   // block_last
  output logic       out_tuser    // bad_header
);

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic        halted_r, halted_nxt;
  logic        pad_r, pad_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [7:0]  map_r, map_nxt;
  logic [2:0]  pidx_r, pidx_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [3:0]  rcnt_r, rcnt_nxt;
  logic [63:0] cur_r, cur_nxt;
  logic [63:0] even_r, even_nxt;
  logic [3:0]  rlen_r, rlen_nxt;
  logic [6:0]  raw_r, raw_nxt;
  logic        single_r, single_nxt;
  logic        ready_r, ready_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  fl_r, fl_nxt;
  logic [7:0]  repb_r, repb_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        olast_r, olast_nxt;
  logic        obad_r, obad_nxt;

  logic [7:0]  rb_r [REPLAY_DEPTH];
  logic        rb_we;
  logic [3:0]  rb_waddr;
  logic [7:0]  rb_wdata;

  logic        can_emit;
  logic [7:0]  pred_lo;
  logic [7:0]  b;
  logic [6:0]  raw_inc;
  logic [63:0] e2;
  logic [7:0]  rep_sel;

  assign can_emit = !ovalid_r || out_tready;
  assign pred_lo  = (pidx_r[0] ? hdr_r[4] : hdr_r[5]) ? 8'hFF : 8'h00;
  assign b        = q_in.item.data;
  assign raw_inc  = raw_r + 1'b1;
  assign e2       = hdr_r[7] ? (even_r ^ cur_r) : even_r;

  always_comb begin
    rep_sel = repb_r;
    if (fl_r[7] && (idx_r < rlen_r) && (idx_r < 4'(REPLAY_DEPTH))) begin
      rep_sel = rb_r[idx_r];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    halted_nxt = halted_r;
    pad_nxt    = pad_r;
    hdr_nxt    = hdr_r;
    map_nxt    = map_r;
    pidx_nxt   = pidx_r;
    flags_nxt  = flags_r;
    rcnt_nxt   = rcnt_r;
    cur_nxt    = cur_r;
    even_nxt   = even_r;
    rlen_nxt   = rlen_r;
    raw_nxt    = raw_r;
    single_nxt = single_r;
    ready_nxt  = ready_r;
    k_nxt      = k_r;
    idx_nxt    = idx_r;
    fl_nxt     = fl_r;
    repb_nxt   = repb_r;
    ovalid_nxt = ovalid_r && !out_tready;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    obad_nxt   = obad_r;
    rb_we      = 1'b0;
    rb_waddr   = '0;
    rb_wdata   = '0;
    q_pop      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_in.valid && can_emit) begin
          q_pop   = 1'b1;
          pad_nxt = q_in.item.last;
          if (!halted_r) begin
            case (phase_r)
              PH_HEADER: begin
                if (b >= HDR_BAD_MIN) begin
                  halted_nxt = 1'b1;
                  ovalid_nxt = 1'b1;
                  obyte_nxt  = '0;
                  olast_nxt  = 1'b0;
                  obad_nxt   = 1'b1;
                end else if (b == HDR_RAW) begin
                  raw_nxt   = '0;
                  phase_nxt = PH_RAW;
                  if (q_in.item.last) begin
                    state_nxt = ST_RAWPAD;
                  end
                end else begin
                  hdr_nxt    = b;
                  single_nxt = 1'b0;
                  ready_nxt  = 1'b0;
                  rlen_nxt   = '0;
                  pidx_nxt   = '0;
                  if (b[1]) begin
                    phase_nxt = PH_MAP;
                    if (q_in.item.last) begin
                      // Missing map byte counts as zero.
                      map_nxt   = '0;
                      state_nxt = ST_PLANES;
                    end
                  end else begin
                    map_nxt   = short_map(b[3:2]);
                    state_nxt = ST_PLANES;
                  end
                end
              end
              PH_RAW: begin
                raw_nxt    = raw_inc;
                ovalid_nxt = 1'b1;
                obyte_nxt  = b;
                olast_nxt  = (raw_inc == 7'(BLOCK_BYTES));
                obad_nxt   = 1'b0;
                if (raw_inc == 7'(BLOCK_BYTES)) begin
                  phase_nxt = PH_HEADER;
                end else if (q_in.item.last) begin
                  state_nxt = ST_RAWPAD;
                end
              end
              PH_MAP: begin
                map_nxt    = b;
                single_nxt = hdr_r[2] && (b != 8'h00);
                state_nxt  = ST_PLANES;
              end
              PH_FLAGS: begin
                if (single_r && !ready_r) begin
                  rb_we    = 1'b1;
                  rb_waddr = '0;
                  rb_wdata = b;
                  rlen_nxt = 4'd1;
                end
                flags_nxt = b;
                rcnt_nxt  = '0;
                state_nxt = ST_ROWS;
              end
              PH_ROWS: begin
                if (single_r && !ready_r && (rlen_r < 4'(REPLAY_DEPTH))) begin
                  rb_we    = 1'b1;
                  rb_waddr = rlen_r;
                  rb_wdata = b;
                  rlen_nxt = rlen_r + 1'b1;
                end
                cur_nxt   = {cur_r[55:0], b};
                flags_nxt = {flags_r[6:0], 1'b0};
                rcnt_nxt  = rcnt_r + 1'b1;
                state_nxt = ST_ROWS;
              end
              default: begin
                phase_nxt = PH_HEADER;
              end
            endcase
          end
        end
      end

      ST_RAWPAD: begin
        if (can_emit) begin
          raw_nxt    = raw_inc;
          ovalid_nxt = 1'b1;
          obyte_nxt  = '0;
          olast_nxt  = (raw_inc == 7'(BLOCK_BYTES));
          obad_nxt   = 1'b0;
          if (raw_inc == 7'(BLOCK_BYTES)) begin
            phase_nxt = PH_HEADER;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_PLANES: begin
        cur_nxt = {8{pred_lo}};
        if (map_r[7]) begin
          if (single_r && ready_r) begin
            fl_nxt    = (rlen_r >= 4'd1) ? rb_r[0] : 8'h00;
            idx_nxt   = 4'd1;
            k_nxt     = '0;
            repb_nxt  = pred_lo;
            state_nxt = ST_REPLAY;
          end else begin
            phase_nxt = PH_FLAGS;
            if (pad_r) begin
              // Missing flag byte counts as zero.
              map_nxt = '0;
              if (single_r && !ready_r) begin
                rb_we    = 1'b1;
                rb_waddr = '0;
                rb_wdata = '0;
                rlen_nxt = 4'd1;
              end
              flags_nxt = '0;
              rcnt_nxt  = '0;
              state_nxt = ST_ROWS;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_ROWS: begin
        if (rcnt_r[3]) begin
          state_nxt = ST_ENDC;
        end else if (!flags_r[7]) begin
          cur_nxt   = {cur_r[55:0], cur_r[7:0]};
          flags_nxt = {flags_r[6:0], 1'b0};
          rcnt_nxt  = rcnt_r + 1'b1;
        end else begin
          phase_nxt = PH_ROWS;
          if (pad_r) begin
            map_nxt   = '0;
            flags_nxt = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_REPLAY: begin
        if (fl_r[7] && (idx_r < rlen_r) && (idx_r < 4'(REPLAY_DEPTH))) begin
          idx_nxt = idx_r + 1'b1;
        end
        repb_nxt = rep_sel;
        cur_nxt  = {cur_r[55:0], rep_sel};
        fl_nxt   = {fl_r[6:0], 1'b0};
        k_nxt    = k_r + 1'b1;
        if (k_r == 4'd7) begin
          state_nxt = ST_ENDC;
        end
      end

      ST_ENDC: begin
        if (hdr_r[0]) begin
          cur_nxt = transpose8x8(cur_r);
        end
        if (single_r) begin
          ready_nxt = 1'b1;
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        map_nxt = {map_r[6:0], 1'b0};
        if (pidx_r[0]) begin
          even_nxt  = e2;
          cur_nxt   = hdr_r[6] ? (cur_r ^ e2) : cur_r;
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          even_nxt  = cur_r;
          pidx_nxt  = pidx_r + 1'b1;
          state_nxt = ST_PLANES;
        end
      end

      ST_EMIT: begin
        if (can_emit) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = k_r[3] ? cur_r[8*k_r[2:0] +: 8] : even_r[8*k_r[2:0] +: 8];
          olast_nxt  = (pidx_r == 3'd7) && (k_r == 4'd15);
          obad_nxt   = 1'b0;
          k_nxt      = k_r + 1'b1;
          if (k_r == 4'd15) begin
            pidx_nxt = pidx_r + 1'b1;
            if (pidx_r == 3'd7) begin
              phase_nxt = PH_HEADER;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_PLANES;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_HEADER;
      halted_r <= 1'b0;
      pad_r    <= 1'b0;
      hdr_r    <= '0;
      map_r    <= '0;
      pidx_r   <= '0;
      flags_r  <= '0;
      rcnt_r   <= '0;
      cur_r    <= '0;
      even_r   <= '0;
      rlen_r   <= '0;
      raw_r    <= '0;
      single_r <= 1'b0;
      ready_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      halted_r <= halted_nxt;
      pad_r    <= pad_nxt;
      hdr_r    <= hdr_nxt;
      map_r    <= map_nxt;
      pidx_r   <= pidx_nxt;
      flags_r  <= flags_nxt;
      rcnt_r   <= rcnt_nxt;
      cur_r    <= cur_nxt;
      even_r   <= even_nxt;
      rlen_r   <= rlen_nxt;
      raw_r    <= raw_nxt;
      single_r <= single_nxt;
      ready_r  <= ready_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    idx_r   <= idx_nxt;
    fl_r    <= fl_nxt;
    repb_r  <= repb_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    obad_r  <= obad_nxt;
    if (rb_we) begin
      rb_r[rb_waddr] <= rb_wdata;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = obad_r;

endmodule

// File: src/planar_tile_block_decompressor_unit.sv
// Planar tile block decompressor. Compressed bytes enter on the in_ stream
// (tlast marks the final byte of a stream) and decoded 64-byte tile blocks
// leave on the out_ stream, with tlast on the 64th byte and tuser set on the
// single result of a bad header, after which the unit drops all input until
// reset. A small input queue decouples the two sides. A raw block byte is
// passed straight to the output. A coded plane is set up (plane start and
// flag byte), then its repeated rows and the rows read from the stream are
// built and the plane is finished; a replayed plane has its rows replayed
// and is then finished. Each plane pair then drives 16 output bytes. All of
// this is done by the single decoder sequencer.
// ----------------------------------------------------------------------------
// planar_tile_block_decompressor_unit
// Top level: input queue feeding the block decoder.
// ----------------------------------------------------------------------------
module planar_tile_block_decompressor_unit import ptbd_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // block_last
  output logic       out_tuser   // [0] bad_header
);

  queue_out_t q;
  logic       q_pop;

  ptbd_front #(.DEPTH(QDEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_out     (q),
    .q_pop     (q_pop)
  );

  ptbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // The error result never closes a block.
  a_bad_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser && out_tlast))
    else $error("bad header result flagged as block end");

  // Once the error result is taken, the unit stays silent.
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser) |=> !out_tvalid)
    else $error("output after bad header");

  // A second check that the unit stays silent after the error result is taken.
  a_last_no_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser) |=> ##1 !out_tvalid)
    else $error("output resumed after halt");
`endif

endmodule
